// ===== rtl/weighted_graph_shortest_path_core_macros.svh =====
// Assertion macros used by the graph engine datapath.
`ifndef WEIGHTED_GRAPH_SHORTEST_PATH_CORE_MACROS_SVH
`define WEIGHTED_GRAPH_SHORTEST_PATH_CORE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define WSP_CHECK_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define WSP_CHECK_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its cause.
`define WSP_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wsp_pkg.sv =====
// Shared types, codes and constants of the graph engine.
package wsp_pkg;

    localparam int DEF_NODES       = 32;
    localparam int DEF_WEIGHT_BITS = 15;
    localparam int FUNC_W          = 3;
    localparam int NODE_W          = 5;
    localparam int WEIGHT_W        = 16;
    localparam int DIST_W          = 20;
    localparam int STATUS_W        = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD_NODE    = 3'd0,
        FN_ADD_EDGE    = 3'd1,
        FN_REMOVE_EDGE = 3'd2,
        FN_UPDATE_EDGE = 3'd3,
        FN_REMOVE_NODE = 3'd4,
        FN_PATH        = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_SAME_ENDPOINTS = 3'd1,
        ST_BAD_WEIGHT     = 3'd2,
        ST_NODE_MISSING   = 3'd3,
        ST_EXISTS         = 3'd4,
        ST_EDGE_MISSING   = 3'd5,
        ST_UNREACHABLE    = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR_STEP,
        CMD_TAKE,
        CMD_LOOK,
        CMD_JUDGE,
        CMD_WRITE_AB,
        CMD_WRITE_BA,
        CMD_DROP_STEP,
        CMD_Q_START,
        CMD_RELAX,
        CMD_ROUND_END,
        CMD_WALK_READ,
        CMD_WALK_STORE,
        CMD_EMIT_LOAD,
        CMD_STATUS_LOAD
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_JUDGE,
        S_DISPATCH,
        S_WRITE_AB,
        S_WRITE_BA,
        S_DROP,
        S_Q_START,
        S_RELAX,
        S_ROUND_END,
        S_WALK_READ,
        S_WALK_STORE,
        S_EMIT_READ,
        S_EMIT_LOAD,
        S_REPORT
    } state_t;

    typedef struct packed {
        func_t func;
        logic  st_ok;
        logic  clear_done;
        logic  drop_done;
        logic  relax_done;
        logic  min_valid;
        logic  dst_reached;
        logic  walk_done;
        logic  emit_last;
        logic  out_busy;
    } stat_t;

endpackage

// ===== rtl/wsp_in_if.sv =====
// Operation item channel of the graph engine.
interface wsp_in_if;
    logic                              valid;
    logic                              ready;
    logic [wsp_pkg::FUNC_W-1:0]        func;
    logic [wsp_pkg::NODE_W-1:0]        first_node;
    logic [wsp_pkg::NODE_W-1:0]        second_node;
    logic signed [wsp_pkg::WEIGHT_W-1:0] weight;

    modport source (output valid, func, first_node, second_node, weight, input ready);
    modport sink (input valid, func, first_node, second_node, weight, output ready);
endinterface

// ===== rtl/wsp_out_if.sv =====
// Result item channel of the graph engine.
interface wsp_out_if;
    logic                          valid;
    logic                          ready;
    logic [wsp_pkg::STATUS_W-1:0]  status;
    logic [wsp_pkg::NODE_W-1:0]    path_node;
    logic [wsp_pkg::DIST_W-1:0]    total_distance;
    logic                          last;

    modport source (output valid, status, path_node, total_distance, last, input ready);
    modport sink (input valid, status, path_node, total_distance, last, output ready);
endinterface

// ===== rtl/wsp_ctrl.sv =====
// Controller state machine of the graph engine.
module wsp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  wsp_pkg::stat_t  stat,
    output wsp_pkg::cmd_t   cmd
);

    wsp_pkg::state_t state_reg;
    wsp_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsp_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsp_pkg::S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = wsp_pkg::S_IDLE;
                end
            end
            wsp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wsp_pkg::S_LOOK;
                end
            end
            wsp_pkg::S_LOOK:      state_next = wsp_pkg::S_JUDGE;
            wsp_pkg::S_JUDGE:     state_next = wsp_pkg::S_DISPATCH;
            wsp_pkg::S_DISPATCH:
            begin
                if (!stat.st_ok)
                begin
                    state_next = wsp_pkg::S_REPORT;
                end
                else if (stat.func inside {wsp_pkg::FN_ADD_EDGE, wsp_pkg::FN_REMOVE_EDGE,
                                           wsp_pkg::FN_UPDATE_EDGE})
                begin
                    state_next = wsp_pkg::S_WRITE_AB;
                end
                else if (stat.func == wsp_pkg::FN_REMOVE_NODE)
                begin
                    state_next = wsp_pkg::S_DROP;
                end
                else if (stat.func == wsp_pkg::FN_PATH)
                begin
                    state_next = wsp_pkg::S_Q_START;
                end
                else
                begin
                    state_next = wsp_pkg::S_REPORT;
                end
            end
            wsp_pkg::S_WRITE_AB:  state_next = wsp_pkg::S_WRITE_BA;
            wsp_pkg::S_WRITE_BA:  state_next = wsp_pkg::S_REPORT;
            wsp_pkg::S_DROP:
            begin
                if (stat.drop_done)
                begin
                    state_next = wsp_pkg::S_REPORT;
                end
            end
            wsp_pkg::S_Q_START:   state_next = wsp_pkg::S_RELAX;
            wsp_pkg::S_RELAX:
            begin
                if (stat.relax_done)
                begin
                    state_next = wsp_pkg::S_ROUND_END;
                end
            end
            wsp_pkg::S_ROUND_END:
            begin
                if (stat.min_valid)
                begin
                    state_next = wsp_pkg::S_RELAX;
                end
                else if (stat.dst_reached)
                begin
                    state_next = wsp_pkg::S_WALK_READ;
                end
                else
                begin
                    state_next = wsp_pkg::S_REPORT;
                end
            end
            wsp_pkg::S_WALK_READ: state_next = wsp_pkg::S_WALK_STORE;
            wsp_pkg::S_WALK_STORE:
            begin
                if (stat.walk_done)
                begin
                    state_next = wsp_pkg::S_EMIT_READ;
                end
                else
                begin
                    state_next = wsp_pkg::S_WALK_READ;
                end
            end
            wsp_pkg::S_EMIT_READ: state_next = wsp_pkg::S_EMIT_LOAD;
            wsp_pkg::S_EMIT_LOAD:
            begin
                if (!stat.out_busy)
                begin
                    state_next = stat.emit_last ? wsp_pkg::S_IDLE : wsp_pkg::S_EMIT_READ;
                end
            end
            wsp_pkg::S_REPORT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = wsp_pkg::S_IDLE;
                end
            end
            default:              state_next = wsp_pkg::S_CLEAR;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = wsp_pkg::CMD_NONE;
        in_ready = 1'b0;
        case (state_reg)
            wsp_pkg::S_CLEAR:      cmd = wsp_pkg::CMD_CLEAR_STEP;
            wsp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = wsp_pkg::CMD_TAKE;
                end
            end
            wsp_pkg::S_LOOK:       cmd = wsp_pkg::CMD_LOOK;
            wsp_pkg::S_JUDGE:      cmd = wsp_pkg::CMD_JUDGE;
            wsp_pkg::S_WRITE_AB:   cmd = wsp_pkg::CMD_WRITE_AB;
            wsp_pkg::S_WRITE_BA:   cmd = wsp_pkg::CMD_WRITE_BA;
            wsp_pkg::S_DROP:       cmd = wsp_pkg::CMD_DROP_STEP;
            wsp_pkg::S_Q_START:    cmd = wsp_pkg::CMD_Q_START;
            wsp_pkg::S_RELAX:      cmd = wsp_pkg::CMD_RELAX;
            wsp_pkg::S_ROUND_END:  cmd = wsp_pkg::CMD_ROUND_END;
            wsp_pkg::S_WALK_READ:  cmd = wsp_pkg::CMD_WALK_READ;
            wsp_pkg::S_WALK_STORE: cmd = wsp_pkg::CMD_WALK_STORE;
            wsp_pkg::S_EMIT_LOAD:
            begin
                if (!stat.out_busy)
                begin
                    cmd = wsp_pkg::CMD_EMIT_LOAD;
                end
            end
            wsp_pkg::S_REPORT:
            begin
                if (!stat.out_busy)
                begin
                    cmd = wsp_pkg::CMD_STATUS_LOAD;
                end
            end
            default:               cmd = wsp_pkg::CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/wsp_datapath.sv =====
// Datapath of the graph engine: weight matrix, query scratch memories and result register.
`include "weighted_graph_shortest_path_core_macros.svh"

module wsp_datapath #(
    parameter int NODES       = wsp_pkg::DEF_NODES,
    parameter int WEIGHT_BITS = wsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wsp_pkg::cmd_t                       cmd,
    input  logic [wsp_pkg::FUNC_W-1:0]          in_func,
    input  logic [wsp_pkg::NODE_W-1:0]          in_first_node,
    input  logic [wsp_pkg::NODE_W-1:0]          in_second_node,
    input  logic signed [wsp_pkg::WEIGHT_W-1:0] in_weight,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [wsp_pkg::STATUS_W-1:0]        out_status,
    output logic [wsp_pkg::NODE_W-1:0]          out_path_node,
    output logic [wsp_pkg::DIST_W-1:0]          out_total_distance,
    output logic                                out_last,
    output wsp_pkg::stat_t                      stat
);

    localparam int IW    = $clog2(NODES);
    localparam int CELLS = NODES * NODES;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = wsp_pkg::DIST_W;
    localparam int SW    = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 1;
    localparam logic [31:0]   WMAX   = (32'd1 << WEIGHT_BITS) - 32'd1;
    localparam logic [SW-1:0] DMAX_S = SW'(wsp_pkg::DIST_MAX);

    function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] row,
                                               input logic [IW-1:0] col);
        mat_addr = AW'(row) * AW'(NODES) + AW'(col);
    endfunction

    // Captured operation.
    wsp_pkg::func_t                 func_reg;
    logic [wsp_pkg::NODE_W-1:0]     a_reg;
    logic [wsp_pkg::NODE_W-1:0]     b_reg;
    logic [wsp_pkg::WEIGHT_W-1:0]   w_reg;
    wsp_pkg::status_t               st_reg;

    // Graph state.
    logic [NODES-1:0]               present_reg;
    logic [WEIGHT_BITS-1:0]         edge_mem [CELLS];
    logic [WEIGHT_BITS-1:0]         edge_rd_reg;
    logic [AW-1:0]                  clear_cnt_reg;
    logic [IW-1:0]                  drop_idx_reg;
    logic                           drop_col_reg;

    // Query state.
    logic [DW-1:0]                  dist_mem [NODES];
    logic [IW-1:0]                  par_mem [NODES];
    logic [IW-1:0]                  route_mem [NODES];
    logic [DW-1:0]                  dist_rd_reg;
    logic [IW-1:0]                  par_rd_reg;
    logic [IW-1:0]                  route_rd_reg;
    logic [NODES-1:0]               reached_reg;
    logic [NODES-1:0]               settled_reg;
    logic [IW-1:0]                  pick_reg;
    logic [DW-1:0]                  pick_dist_reg;
    logic [IW:0]                    issue_cnt_reg;
    logic                           s1_valid_reg;
    logic [IW-1:0]                  s1_idx_reg;
    logic                           min_valid_reg;
    logic [IW-1:0]                  min_idx_reg;
    logic [DW-1:0]                  min_dist_reg;
    logic [IW-1:0]                  cur_reg;
    logic [IW:0]                    n_reg;
    logic [IW-1:0]                  emit_idx_reg;
    logic [DW-1:0]                  total_reg;

    // Result register.
    logic                           out_valid_reg;
    logic [wsp_pkg::STATUS_W-1:0]   out_status_reg;
    logic [wsp_pkg::NODE_W-1:0]     out_node_reg;
    logic [DW-1:0]                  out_dist_reg;
    logic                           out_last_reg;

    // Decoded operands.
    logic [IW-1:0]          ai;
    logic [IW-1:0]          bi;
    logic                   a_ok;
    logic                   b_ok;
    logic                   here_a;
    logic                   here_b;
    logic                   w_bad;
    logic [31:0]            w_ext;
    logic [WEIGHT_BITS-1:0] w_sat;
    logic                   edge_there;
    wsp_pkg::status_t       judge_st;

    assign ai     = IW'(a_reg);
    assign bi     = IW'(b_reg);
    assign a_ok   = 32'(a_reg) < 32'(NODES);
    assign b_ok   = 32'(b_reg) < 32'(NODES);
    assign here_a = a_ok && present_reg[ai];
    assign here_b = b_ok && present_reg[bi];
    assign w_bad  = (w_reg == '0) || w_reg[wsp_pkg::WEIGHT_W-1];
    assign w_ext  = 32'(w_reg);
    assign w_sat  = (w_ext > WMAX) ? WEIGHT_BITS'(WMAX) : WEIGHT_BITS'(w_ext);
    assign edge_there = (edge_rd_reg != '0);

    // Status of an operation, checks in priority order.
    always_comb
    begin
        judge_st = wsp_pkg::ST_OK;
        case (func_reg)
            wsp_pkg::FN_ADD_NODE:
            begin
                if (!a_ok)                         judge_st = wsp_pkg::ST_NODE_MISSING;
                else if (present_reg[ai])          judge_st = wsp_pkg::ST_EXISTS;
            end
            wsp_pkg::FN_ADD_EDGE:
            begin
                if (a_reg == b_reg)                judge_st = wsp_pkg::ST_SAME_ENDPOINTS;
                else if (w_bad)                    judge_st = wsp_pkg::ST_BAD_WEIGHT;
                else if (!a_ok || !b_ok)           judge_st = wsp_pkg::ST_NODE_MISSING;
                else if (edge_there)               judge_st = wsp_pkg::ST_EXISTS;
            end
            wsp_pkg::FN_REMOVE_EDGE:
            begin
                if (!here_a || !here_b)            judge_st = wsp_pkg::ST_NODE_MISSING;
            end
            wsp_pkg::FN_UPDATE_EDGE:
            begin
                if (a_reg == b_reg)                judge_st = wsp_pkg::ST_SAME_ENDPOINTS;
                else if (w_bad)                    judge_st = wsp_pkg::ST_BAD_WEIGHT;
                else if (!here_a || !here_b)       judge_st = wsp_pkg::ST_NODE_MISSING;
                else if (!edge_there)              judge_st = wsp_pkg::ST_EDGE_MISSING;
            end
            wsp_pkg::FN_REMOVE_NODE:
            begin
                if (!here_a)                       judge_st = wsp_pkg::ST_NODE_MISSING;
            end
            wsp_pkg::FN_PATH:
            begin
                if (!here_a || !here_b)            judge_st = wsp_pkg::ST_NODE_MISSING;
            end
            default:                               judge_st = wsp_pkg::ST_OK;
        endcase
    end

    // Weight matrix ports.
    logic                   e_we;
    logic [AW-1:0]          e_waddr;
    logic [WEIGHT_BITS-1:0] e_wdata;
    logic [AW-1:0]          e_raddr;
    logic                   issuing;

    assign issuing = (cmd == wsp_pkg::CMD_RELAX) && (issue_cnt_reg < (IW + 1)'(NODES));
    assign e_raddr = (cmd == wsp_pkg::CMD_LOOK) ? mat_addr(ai, bi)
                                                : mat_addr(pick_reg, issue_cnt_reg[IW-1:0]);

    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = clear_cnt_reg;
        e_wdata = '0;
        case (cmd)
            wsp_pkg::CMD_CLEAR_STEP:
            begin
                e_we = 1'b1;
            end
            wsp_pkg::CMD_WRITE_AB:
            begin
                e_we    = 1'b1;
                e_waddr = mat_addr(ai, bi);
                e_wdata = (func_reg == wsp_pkg::FN_REMOVE_EDGE) ? '0 : w_sat;
            end
            wsp_pkg::CMD_WRITE_BA:
            begin
                e_we    = 1'b1;
                e_waddr = mat_addr(bi, ai);
                e_wdata = (func_reg == wsp_pkg::FN_REMOVE_EDGE) ? '0 : w_sat;
            end
            wsp_pkg::CMD_DROP_STEP:
            begin
                e_we    = 1'b1;
                e_waddr = drop_col_reg ? mat_addr(drop_idx_reg, ai) : mat_addr(ai, drop_idx_reg);
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_waddr] <= e_wdata;
        end
        edge_rd_reg <= edge_mem[e_raddr];
    end

    // Relaxation stage: one neighbor of the settled node per cycle.
    logic [SW-1:0] cand;
    logic [DW-1:0] cand_sat;
    logic          s1_set;
    logic          s1_rch;
    logic          upd;
    logic [DW-1:0] new_d;
    logic          take_min;

    assign cand     = SW'(pick_dist_reg) + SW'(edge_rd_reg);
    assign cand_sat = (cand > DMAX_S) ? wsp_pkg::DIST_MAX : DW'(cand);
    assign s1_set   = settled_reg[s1_idx_reg];
    assign s1_rch   = reached_reg[s1_idx_reg];
    assign upd      = s1_valid_reg && (edge_rd_reg != '0) && !s1_set
                      && (!s1_rch || (cand_sat < dist_rd_reg));
    assign new_d    = upd ? cand_sat : dist_rd_reg;
    assign take_min = s1_valid_reg && (s1_rch || upd) && !s1_set
                      && (!min_valid_reg || (new_d < min_dist_reg));

    // Distance and parent memories.
    logic          dp_we;
    logic [IW-1:0] dp_waddr;
    logic [DW-1:0] dist_wd;
    logic [IW-1:0] par_wd;
    logic [IW-1:0] dp_raddr;

    assign dp_raddr = (cmd == wsp_pkg::CMD_WALK_READ) ? cur_reg : issue_cnt_reg[IW-1:0];

    always_comb
    begin
        dp_we    = upd;
        dp_waddr = s1_idx_reg;
        dist_wd  = cand_sat;
        par_wd   = pick_reg;
        if (cmd == wsp_pkg::CMD_Q_START)
        begin
            dp_we    = 1'b1;
            dp_waddr = ai;
            dist_wd  = '0;
            par_wd   = ai;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_we)
        begin
            dist_mem[dp_waddr] <= dist_wd;
            par_mem[dp_waddr]  <= par_wd;
        end
        dist_rd_reg <= dist_mem[dp_raddr];
        par_rd_reg  <= par_mem[dp_raddr];
    end

    // Route buffer, filled destination first and read back in reverse.
    always_ff @(posedge clk)
    begin
        if (cmd == wsp_pkg::CMD_WALK_STORE)
        begin
            route_mem[n_reg[IW-1:0]] <= cur_reg;
        end
        route_rd_reg <= route_mem[emit_idx_reg];
    end

    logic walk_done;
    assign walk_done = (cur_reg == ai) || (n_reg == (IW + 1)'(NODES - 1));

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            clear_cnt_reg <= '0;
            reached_reg   <= '0;
            settled_reg   <= '0;
            issue_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            min_valid_reg <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issuing;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (upd)
            begin
                reached_reg[s1_idx_reg] <= 1'b1;
            end
            if (take_min)
            begin
                min_valid_reg <= 1'b1;
            end
            case (cmd)
                wsp_pkg::CMD_CLEAR_STEP:
                begin
                    clear_cnt_reg <= clear_cnt_reg + AW'(1);
                end
                wsp_pkg::CMD_JUDGE:
                begin
                    if (func_reg == wsp_pkg::FN_ADD_NODE && judge_st == wsp_pkg::ST_OK)
                    begin
                        present_reg[ai] <= 1'b1;
                    end
                    if (func_reg == wsp_pkg::FN_ADD_EDGE
                        && (judge_st == wsp_pkg::ST_OK || judge_st == wsp_pkg::ST_EXISTS))
                    begin
                        present_reg[ai] <= 1'b1;
                        present_reg[bi] <= 1'b1;
                    end
                    if (func_reg == wsp_pkg::FN_REMOVE_NODE && judge_st == wsp_pkg::ST_OK)
                    begin
                        present_reg[ai] <= 1'b0;
                    end
                end
                wsp_pkg::CMD_Q_START:
                begin
                    reached_reg   <= {{(NODES - 1){1'b0}}, 1'b1} << ai;
                    settled_reg   <= {{(NODES - 1){1'b0}}, 1'b1} << ai;
                    issue_cnt_reg <= '0;
                    min_valid_reg <= 1'b0;
                    n_reg         <= '0;
                end
                wsp_pkg::CMD_RELAX:
                begin
                    if (issuing)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + (IW + 1)'(1);
                    end
                end
                wsp_pkg::CMD_ROUND_END:
                begin
                    if (min_valid_reg)
                    begin
                        settled_reg[min_idx_reg] <= 1'b1;
                        min_valid_reg            <= 1'b0;
                        issue_cnt_reg            <= '0;
                    end
                end
                wsp_pkg::CMD_WALK_STORE:
                begin
                    n_reg <= n_reg + (IW + 1)'(1);
                end
                wsp_pkg::CMD_EMIT_LOAD, wsp_pkg::CMD_STATUS_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg == 1'b0 && issuing)
        begin
            s1_idx_reg <= issue_cnt_reg[IW-1:0];
        end
        else if (issuing)
        begin
            s1_idx_reg <= issue_cnt_reg[IW-1:0];
        end
        if (take_min)
        begin
            min_idx_reg  <= s1_idx_reg;
            min_dist_reg <= new_d;
        end
        case (cmd)
            wsp_pkg::CMD_TAKE:
            begin
                func_reg     <= wsp_pkg::func_t'(in_func);
                a_reg        <= in_first_node;
                b_reg        <= in_second_node;
                w_reg        <= in_weight;
                drop_idx_reg <= '0;
                drop_col_reg <= 1'b0;
            end
            wsp_pkg::CMD_JUDGE:
            begin
                st_reg <= judge_st;
            end
            wsp_pkg::CMD_DROP_STEP:
            begin
                if (drop_idx_reg == IW'(NODES - 1))
                begin
                    drop_idx_reg <= '0;
                    drop_col_reg <= 1'b1;
                end
                else
                begin
                    drop_idx_reg <= drop_idx_reg + IW'(1);
                end
            end
            wsp_pkg::CMD_Q_START:
            begin
                pick_reg      <= ai;
                pick_dist_reg <= '0;
                cur_reg       <= bi;
            end
            wsp_pkg::CMD_ROUND_END:
            begin
                if (min_valid_reg)
                begin
                    pick_reg      <= min_idx_reg;
                    pick_dist_reg <= min_dist_reg;
                end
                else if (!reached_reg[bi])
                begin
                    st_reg <= wsp_pkg::ST_UNREACHABLE;
                end
            end
            wsp_pkg::CMD_WALK_STORE:
            begin
                if (n_reg == '0)
                begin
                    total_reg <= dist_rd_reg;
                end
                cur_reg <= par_rd_reg;
                if (walk_done)
                begin
                    emit_idx_reg <= n_reg[IW-1:0];
                end
            end
            wsp_pkg::CMD_EMIT_LOAD:
            begin
                out_status_reg <= wsp_pkg::ST_OK;
                out_node_reg   <= wsp_pkg::NODE_W'(route_rd_reg);
                out_dist_reg   <= total_reg;
                out_last_reg   <= (emit_idx_reg == '0);
                emit_idx_reg   <= emit_idx_reg - IW'(1);
            end
            wsp_pkg::CMD_STATUS_LOAD:
            begin
                out_status_reg <= st_reg;
                out_node_reg   <= '0;
                out_dist_reg   <= '0;
                out_last_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Status to the controller.
    always_comb
    begin
        stat.func        = func_reg;
        stat.st_ok       = (st_reg == wsp_pkg::ST_OK);
        stat.clear_done  = (clear_cnt_reg == AW'(CELLS - 1));
        stat.drop_done   = drop_col_reg && (drop_idx_reg == IW'(NODES - 1));
        stat.relax_done  = s1_valid_reg && (s1_idx_reg == IW'(NODES - 1));
        stat.min_valid   = min_valid_reg;
        stat.dst_reached = reached_reg[bi];
        stat.walk_done   = walk_done;
        stat.emit_last   = (emit_idx_reg == '0);
        stat.out_busy    = out_valid_reg;
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_path_node      = out_node_reg;
    assign out_total_distance = out_dist_reg;
    assign out_last           = out_last_reg;

    // A node is settled only once it has been reached.
    `WSP_CHECK_ALWAYS(a_settled_reached, (settled_reg & ~reached_reg) == '0, "settled node not reached")
    // Each closing round with a candidate settles exactly one more node.
    `WSP_CHECK_NEXT(a_round_settles_one, cmd == wsp_pkg::CMD_ROUND_END && min_valid_reg, $countones(settled_reg) == $past($countones(settled_reg)) + 1, "round did not settle one node")
    // The path walk never stores more nodes than the graph holds.
    `WSP_CHECK_ALWAYS(a_walk_bounded, n_reg <= (IW + 1)'(NODES), "route longer than node count")
    // A result appears only after a load command.
    `WSP_CHECK_SAME(a_out_from_load, $rose(out_valid_reg), $past(cmd == wsp_pkg::CMD_EMIT_LOAD || cmd == wsp_pkg::CMD_STATUS_LOAD), "result shown without a load")

endmodule

// ===== rtl/weighted_graph_shortest_path_core.sv =====
// Top level of the weighted graph engine with shortest-path queries.
//
// Channel op takes one operation item (func, first_node, second_node, weight);
// channel res returns result items (status, path_node, total_distance, last).
// Both channels move an item when valid and ready are high at a clock edge.
// Node additions, edge edits and rejected operations give one result each;
// removing a node first sweeps its row and column. A path query runs one
// round per settled node, each round reading one matrix row one entry a
// cycle, then walks the parents back from the destination and emits one
// result item per path node, or one status item when it is unreachable.
// One operation item is worked at a time; the next is taken once the last
// result of the previous one has been placed in the output register.
// After reset the weight matrix is cleared one entry per cycle; op.ready stays
// low until every entry is clear.
// When the receiver stalls, the output register holds its item and the
// engine waits before loading the next one.
module weighted_graph_shortest_path_core #(
    parameter int NODES       = wsp_pkg::DEF_NODES,
    parameter int WEIGHT_BITS = wsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    wsp_in_if.sink       op,
    wsp_out_if.source    res
);

    wsp_pkg::cmd_t  cmd;
    wsp_pkg::stat_t stat;

    // Sequencer.
    wsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (op.valid),
        .in_ready (op.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    wsp_datapath #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .in_func            (op.func),
        .in_first_node      (op.first_node),
        .in_second_node     (op.second_node),
        .in_weight          (op.weight),
        .out_ready          (res.ready),
        .out_valid          (res.valid),
        .out_status         (res.status),
        .out_path_node      (res.path_node),
        .out_total_distance (res.total_distance),
        .out_last           (res.last),
        .stat               (stat)
    );

endmodule

// ===== bench/weighted_graph_shortest_path_core_test.sv =====
// Testbench of the graph engine: directed and random operations checked against a predictor.
`timescale 1ns / 100ps

module weighted_graph_shortest_path_core_test;

    localparam int N = wsp_pkg::DEF_NODES;
    localparam logic [14:0] WMAX = '1;

    // One expected result item.
    typedef struct packed {
        logic [wsp_pkg::STATUS_W-1:0] status;
        logic [wsp_pkg::NODE_W-1:0]   path_node;
        logic [wsp_pkg::DIST_W-1:0]   total_distance;
        logic                         last;
    } answer_t;

    logic clk;
    logic rst_n;
    wsp_in_if  op_ch();
    wsp_out_if res_ch();

    weighted_graph_shortest_path_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .op(op_ch.sink),
        .res(res_ch.source)
    );

    // Predictor state: weight matrix and node present bits.
    logic [14:0] graph_w [N][N];
    logic        present [N];
    answer_t     pending_answers [$];
    int          failures = 0;
    bit          drain_calm = 0;
    bit          hold_sink = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

    // Append one expected result to the queue.
    function automatic void queue_answer(answer_t ans);
        pending_answers = {pending_answers, ans};
    endfunction

    // Dijkstra with lowest-index ties; appends the path results or reports unreachable.
    function automatic logic [wsp_pkg::STATUS_W-1:0] plan_route(int src, int dst);
        logic [wsp_pkg::DIST_W-1:0] best [N];
        int   parent [N];
        bit   done [N];
        bit   seen [N];
        int   route [N];
        int   pick, n, k, cur;
        logic [wsp_pkg::DIST_W:0] d;
        for (int i = 0; i < N; i++)
        begin
            best[i] = 0;
            parent[i] = 0;
            done[i] = 0;
            seen[i] = 0;
        end
        seen[src] = 1;
        parent[src] = src;
        for (int r = 0; r < N; r++)
        begin
            pick = N;
            for (int i = 0; i < N; i++)
                if (seen[i] && !done[i] && (pick == N || best[i] < best[pick]))
                    pick = i;
            if (pick == N)
                break;
            done[pick] = 1;
            for (int i = 0; i < N; i++)
            begin
                if (graph_w[pick][i] == 0 || done[i])
                    continue;
                d = best[pick] + graph_w[pick][i];
                if (d > wsp_pkg::DIST_MAX)
                    d = wsp_pkg::DIST_MAX;
                if (!seen[i] || d[wsp_pkg::DIST_W-1:0] < best[i])
                begin
                    seen[i] = 1;
                    best[i] = d[wsp_pkg::DIST_W-1:0];
                    parent[i] = pick;
                end
            end
        end
        if (!seen[dst])
            return wsp_pkg::ST_UNREACHABLE;
        n = 0;
        cur = dst;
        while (n < N)
        begin
            route[n++] = cur;
            if (cur == src)
                break;
            cur = parent[cur];
        end
        for (k = n - 1; k >= 0; k--)
            queue_answer({3'(wsp_pkg::ST_OK), wsp_pkg::NODE_W'(route[k]), best[dst], k == 0});
        return wsp_pkg::ST_OK;
    endfunction

    // Apply one operation to the predictor and queue its results.
    function automatic void predict_op(logic [2:0] fn, logic [4:0] a, logic [4:0] b,
                                       logic [15:0] w);
        bit bad_w;
        logic [14:0] wsat;
        logic [wsp_pkg::STATUS_W-1:0] st;
        bad_w = (w == 0) || w[15];
        wsat = (w > 16'(WMAX)) ? WMAX : w[14:0];
        st = wsp_pkg::ST_OK;
        case (fn)
            wsp_pkg::FN_ADD_NODE:
                if (present[a]) st = wsp_pkg::ST_EXISTS;
                else present[a] = 1;
            wsp_pkg::FN_ADD_EDGE:
                if (a == b) st = wsp_pkg::ST_SAME_ENDPOINTS;
                else if (bad_w) st = wsp_pkg::ST_BAD_WEIGHT;
                else
                begin
                    present[a] = 1;
                    present[b] = 1;
                    if (graph_w[a][b] != 0) st = wsp_pkg::ST_EXISTS;
                    else
                    begin
                        graph_w[a][b] = wsat;
                        graph_w[b][a] = wsat;
                    end
                end
            wsp_pkg::FN_REMOVE_EDGE:
                if (!present[a] || !present[b]) st = wsp_pkg::ST_NODE_MISSING;
                else
                begin
                    graph_w[a][b] = 0;
                    graph_w[b][a] = 0;
                end
            wsp_pkg::FN_UPDATE_EDGE:
                if (a == b) st = wsp_pkg::ST_SAME_ENDPOINTS;
                else if (bad_w) st = wsp_pkg::ST_BAD_WEIGHT;
                else if (!present[a] || !present[b]) st = wsp_pkg::ST_NODE_MISSING;
                else if (graph_w[a][b] == 0) st = wsp_pkg::ST_EDGE_MISSING;
                else
                begin
                    graph_w[a][b] = wsat;
                    graph_w[b][a] = wsat;
                end
            wsp_pkg::FN_REMOVE_NODE:
                if (!present[a]) st = wsp_pkg::ST_NODE_MISSING;
                else
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        graph_w[a][i] = 0;
                        graph_w[i][a] = 0;
                    end
                    present[a] = 0;
                end
            wsp_pkg::FN_PATH:
                if (!present[a] || !present[b]) st = wsp_pkg::ST_NODE_MISSING;
                else
                begin
                    st = plan_route(a, b);
                    if (st == wsp_pkg::ST_OK)
                        return;
                end
            default: st = wsp_pkg::ST_OK;
        endcase
        queue_answer({st, 5'd0, 20'd0, 1'b1});
    endfunction

    // Send one operation item, with an optional random gap first.
    // Valid stays high after an accepted item until a gap or the final drain.
    task automatic send_op(logic [2:0] fn, logic [4:0] a, logic [4:0] b, logic [15:0] w);
        int gap;
        if (!drain_calm && $urandom_range(0, 3) == 0)
        begin
            op_ch.valid <= 0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        op_ch.valid <= 1;
        op_ch.func <= fn;
        op_ch.first_node <= a;
        op_ch.second_node <= b;
        op_ch.weight <= w;
        @(posedge clk);
        while (!op_ch.ready) @(posedge clk);
        predict_op(fn, a, b, w);
    endtask

    task automatic wait_drain();
        op_ch.valid <= 0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver: random stall bursts, or a long hold when asked.
    initial
    begin
        int gap;
        res_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
                res_ch.ready <= 0;
            else if (!drain_calm && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 0;
                gap = $urandom_range(1, 9);
                repeat (gap - 1) @(posedge clk);
            end
            else
                res_ch.ready <= 1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result status=%0d", res_ch.status);
                failures++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (res_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, res_ch.status);
                    failures++;
                end
                if (res_ch.path_node !== want.path_node)
                begin
                    $error("path_node: expected %0d, actual %0d", want.path_node,
                           res_ch.path_node);
                    failures++;
                end
                if (res_ch.total_distance !== want.total_distance)
                begin
                    $error("total_distance: expected %0d, actual %0d",
                           want.total_distance, res_ch.total_distance);
                    failures++;
                end
                if (res_ch.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, res_ch.last);
                    failures++;
                end
            end
        end
    end

    // Directed cases: every operation, every status and edge weights.
    task automatic test_directed();
        send_op(wsp_pkg::FN_PATH, 0, 1, 1);
        send_op(wsp_pkg::FN_ADD_NODE, 0, 0, 0);
        send_op(wsp_pkg::FN_ADD_NODE, 0, 0, 0);
        send_op(wsp_pkg::FN_ADD_NODE, 31, 0, 0);
        send_op(wsp_pkg::FN_ADD_EDGE, 3, 3, 5);
        send_op(wsp_pkg::FN_ADD_EDGE, 0, 1, 0);
        send_op(wsp_pkg::FN_ADD_EDGE, 0, 1, 16'h8000);
        send_op(wsp_pkg::FN_ADD_EDGE, 0, 1, 16'h7FFF);
        send_op(wsp_pkg::FN_ADD_EDGE, 0, 1, 3);
        send_op(wsp_pkg::FN_ADD_EDGE, 1, 31, 1);
        send_op(wsp_pkg::FN_ADD_EDGE, 0, 2, 10);
        send_op(wsp_pkg::FN_ADD_EDGE, 2, 31, 22767);
        send_op(wsp_pkg::FN_PATH, 0, 31, 0);
        send_op(wsp_pkg::FN_PATH, 31, 31, 0);
        send_op(wsp_pkg::FN_UPDATE_EDGE, 0, 2, 16'hFFFF);
        send_op(wsp_pkg::FN_UPDATE_EDGE, 5, 2, 4);
        send_op(wsp_pkg::FN_UPDATE_EDGE, 0, 31, 4);
        send_op(wsp_pkg::FN_UPDATE_EDGE, 0, 1, 1);
        send_op(wsp_pkg::FN_REMOVE_EDGE, 0, 9, 0);
        send_op(wsp_pkg::FN_REMOVE_EDGE, 1, 31, 0);
        send_op(wsp_pkg::FN_PATH, 0, 31, 0);
        send_op(6, 0, 0, 0);
        send_op(7, 31, 31, 16'hFFFF);
        send_op(wsp_pkg::FN_REMOVE_NODE, 2, 0, 0);
        send_op(wsp_pkg::FN_PATH, 0, 31, 0);
    endtask

    // Long receiver stall while operations keep coming.
    task automatic test_backpressure();
        hold_sink = 1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send_op(wsp_pkg::FN_ADD_NODE, 5'($urandom_range(0, 31)), 0, 0);
            end
            begin
                repeat (300) @(posedge clk);
                hold_sink = 0;
            end
        join
    endtask

    // Random edits and queries over a small cluster of nodes, with noise.
    task automatic test_random(int count, bit calm);
        logic [2:0] fn;
        logic [4:0] a, b;
        logic [15:0] w;
        int sel;
        drain_calm = calm;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel > 5)
                fn = (sel == 9) ? 3'($urandom_range(6, 7)) : 3'(wsp_pkg::FN_ADD_EDGE);
            else
                fn = 3'(sel);
            a = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
            b = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: w = 16'($urandom);
                1: w = 16'($urandom_range(32768, 40000));
                default: w = 16'($urandom_range(1, 300));
            endcase
            send_op(fn, a, b, w);
        end
    endtask

    initial
    begin
        rst_n = 0;
        op_ch.valid = 0;
        op_ch.func = 0;
        op_ch.first_node = 0;
        op_ch.second_node = 0;
        op_ch.weight = 0;
        for (int i = 0; i < N; i++)
        begin
            present[i] = 0;
            for (int j = 0; j < N; j++) graph_w[i][j] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(100, 0);
        test_random(40, 1);
        wait_drain();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
